// ===== rtl/nlt_pkg.sv =====
// Shared types, constants and coefficient tables for the normalized Legendre table block.
package nlt_pkg;

    // Degree/order index and table geometry at the largest supported degree
    localparam int IDX_W     = 4;
    localparam int ROWS_MAX  = 11;
    localparam int TBL_SIZE  = (ROWS_MAX * (ROWS_MAX + 1)) / 2;
    localparam int TBL_IDX_W = $clog2(TBL_SIZE);

    // Datapath widths
    localparam int DATA_W = 32;
    localparam int COEF_W = 32;
    localparam int OPA_W  = 35;
    localparam int PROD_W = OPA_W + DATA_W;
    localparam int ACC_W  = 40;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [TBL_IDX_W-1:0]     t_tbl_idx;
    typedef logic [COEF_W-1:0]        t_coef;
    typedef t_coef                    t_coef_rom [TBL_SIZE];

    localparam logic signed [DATA_W-1:0] ONE_Q24 = 32'sh0100_0000;
    localparam logic signed [ACC_W-1:0]  SAT_HI  =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  SAT_LO  =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        CF_S3, CF_DIAG, CF_A, CF_B, CF_DG, CF_DF
    } t_coef_sel;

    typedef enum logic [1:0] {
        A_COS, A_SIN, A_TMP, A_RD
    } t_asel;

    typedef enum logic [1:0] {
        RND_26, RND_30, RND_32
    } t_rnd_sel;

    typedef enum logic [1:0] {
        OP_TMP, OP_LOAD, OP_SUB
    } t_acc_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P00,
        ST_P10_MUL, ST_P10_RND, ST_P10_WR,
        ST_P11_MUL, ST_P11_RND, ST_P11_WR,
        ST_D_RD, ST_D_MUL1, ST_D_RND1, ST_D_MUL2, ST_D_RND2, ST_D_WR,
        ST_O_RD, ST_O_MUL1, ST_O_RND1, ST_O_MUL2, ST_O_RND2, ST_O_MUL3,
        ST_O_RND3, ST_O_WR,
        ST_E_RDP, ST_E_RDG, ST_E_MULG, ST_E_RNDG, ST_E_MULF, ST_E_RNDF,
        ST_E_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic      in_ld;
        logic      rd_en;
        logic      wr_en;
        logic      wr_one;
        t_idx      addr_row;
        t_idx      addr_col;
        logic      mul_en;
        t_asel     a_sel;
        logic      b_coef;
        t_coef_sel coef_sel;
        t_idx      cur_row;
        t_idx      cur_col;
        logic      rnd_en;
        t_rnd_sel  rnd_sel;
        t_acc_op   acc_op;
        logic      pval_ld;
        logic      out_ld;
        logic      out_last;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_stall;
    } t_stat;

    // Rounded Q.26 square root of num/den, zero when either is zero
    function automatic t_coef f_coef(input longint unsigned num, input longint unsigned den);
        logic [127:0] x;
        logic [127:0] r;
        logic [127:0] t;
        int           b;
        if (num == 0 || den == 0) begin
            return '0;
        end
        x = 128'(num) << 52;
        r = '0;
        for (b = 31; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t * 128'(den) <= x) begin
                r = t;
            end
        end
        if ((r * r + r + 128'd1) * 128'(den) <= x) begin
            r = r + 128'd1;
        end
        return COEF_W'(r);
    endfunction

    // Build one coefficient table over the triangle, row-major
    function automatic t_coef_rom f_build(input t_coef_sel sel);
        t_coef_rom        rom;
        int               n;
        int               m;
        int               k;
        longint unsigned  un;
        longint unsigned  um;
        k = 0;
        for (n = 0; n < ROWS_MAX; n++) begin
            for (m = 0; m <= n; m++) begin
                un = longint'(n);
                um = longint'(m);
                rom[k] = '0;
                case (sel)
                    CF_DIAG: begin
                        if (n >= 1) rom[k] = f_coef(2 * un + 1, 2 * un);
                    end
                    CF_A: begin
                        if (n >= 1 && m < n)
                            rom[k] = f_coef((2 * un + 1) * (2 * un - 1), (un + um) * (un - um));
                    end
                    CF_B: begin
                        if (n >= 2 && m + 1 < n)
                            rom[k] = f_coef((2 * un + 1) * (un + um - 1) * (un - um - 1),
                                            (2 * un - 3) * (un + um) * (un - um));
                    end
                    CF_DG: begin
                        if (m == 1) rom[k] = f_coef(un * (un + 1), 2);
                        else if (m >= 2) rom[k] = f_coef((un + um) * (un - um + 1), 4);
                    end
                    CF_DF: begin
                        if (m == 0) rom[k] = f_coef(un * (un + 1), 2);
                        else rom[k] = f_coef((un - um) * (un + um + 1), 4);
                    end
                    default: rom[k] = '0;
                endcase
                k++;
            end
        end
        return rom;
    endfunction

    localparam t_coef     COEF_S3  = f_coef(3, 1);
    localparam t_coef_rom ROM_DIAG = f_build(CF_DIAG);
    localparam t_coef_rom ROM_A    = f_build(CF_A);
    localparam t_coef_rom ROM_B    = f_build(CF_B);
    localparam t_coef_rom ROM_DG   = f_build(CF_DG);
    localparam t_coef_rom ROM_DF   = f_build(CF_DF);

    // Flat triangle index of (n, m): n(n+1)/2 + m
    function automatic t_tbl_idx f_tri_idx(input t_idx n, input t_idx m);
        logic [7:0] prod;
        prod = {4'b0, n} * ({4'b0, n} + 8'd1);
        return TBL_IDX_W'(prod >> 1) + TBL_IDX_W'(m);
    endfunction

endpackage

// ===== rtl/nlt_dpath.sv =====
// Datapath: table memory, shared multiplier, rounding accumulator and result register.
module nlt_dpath import nlt_pkg::*; #(
    parameter int MAX_DEGREE = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic signed [DATA_W-1:0] i_cos_theta,
    input  logic signed [DATA_W-1:0] i_sin_theta,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output t_idx                     o_degree_index,
    output t_idx                     o_order_index,
    output logic signed [DATA_W-1:0] o_legendre_value,
    output logic signed [DATA_W-1:0] o_derivative_value,
    output logic                     o_last_entry
);

    localparam int ROWS   = MAX_DEGREE + 2;
    localparam int DEPTH  = (ROWS * (ROWS + 1)) / 2;
    localparam int ADDR_W = $clog2(DEPTH);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_cos;
    logic signed [DATA_W-1:0] r_sin;
    logic signed [DATA_W-1:0] r_rd;
    logic signed [DATA_W-1:0] r_pval;
    logic signed [OPA_W-1:0]  r_tmp;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    t_idx                     r_out_n;
    t_idx                     r_out_m;
    logic signed [DATA_W-1:0] r_out_p;
    logic signed [DATA_W-1:0] r_out_d;
    logic                     r_out_last;

    t_tbl_idx                 addr_flat;
    t_tbl_idx                 coef_idx;
    logic [ADDR_W-1:0]        addr;
    t_coef                    coef_val;
    logic signed [OPA_W-1:0]  op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [ACC_W-1:0]  rnd_val;
    logic signed [DATA_W-1:0] acc_sat;
    logic signed [DATA_W-1:0] wr_data;

    // Address and coefficient lookup
    assign addr_flat = f_tri_idx(i_cmd.addr_row, i_cmd.addr_col);
    assign addr      = addr_flat[ADDR_W-1:0];
    assign coef_idx  = f_tri_idx(i_cmd.cur_row, i_cmd.cur_col);

    always_comb begin
        case (i_cmd.coef_sel)
            CF_S3:   coef_val = COEF_S3;
            CF_DIAG: coef_val = ROM_DIAG[coef_idx];
            CF_A:    coef_val = ROM_A[coef_idx];
            CF_B:    coef_val = ROM_B[coef_idx];
            CF_DG:   coef_val = ROM_DG[coef_idx];
            CF_DF:   coef_val = ROM_DF[coef_idx];
            default: coef_val = '0;
        endcase
    end

    // Multiplier operand selection
    always_comb begin
        case (i_cmd.a_sel)
            A_COS:   op_a = OPA_W'(r_cos);
            A_SIN:   op_a = OPA_W'(r_sin);
            A_TMP:   op_a = r_tmp;
            A_RD:    op_a = OPA_W'(r_rd);
            default: op_a = '0;
        endcase
        op_b = i_cmd.b_coef ? signed'(coef_val) : r_rd;
    end

    // Round product to nearest, ties away from zero
    always_comb begin
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sum;
        logic [PROD_W-1:0] q;
        logic [ACC_W-1:0]  qm;
        mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        case (i_cmd.rnd_sel)
            RND_30: begin
                sum = mag + (PROD_W'(1) << 29);
                q   = sum >> 30;
            end
            RND_32: begin
                sum = mag + (PROD_W'(1) << 31);
                q   = sum >> 32;
            end
            default: begin
                sum = mag + (PROD_W'(1) << 25);
                q   = sum >> 26;
            end
        endcase
        qm      = ACC_W'(q);
        rnd_val = r_prod[PROD_W-1] ? -signed'(qm) : signed'(qm);
    end

    // Saturate accumulator to the result range
    always_comb begin
        if (r_acc > SAT_HI) begin
            acc_sat = SAT_HI[DATA_W-1:0];
        end else if (r_acc < SAT_LO) begin
            acc_sat = SAT_LO[DATA_W-1:0];
        end else begin
            acc_sat = r_acc[DATA_W-1:0];
        end
        wr_data = i_cmd.wr_one ? ONE_Q24 : acc_sat;
    end

    // Table memory: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[addr];
        end
    end

    // Hold inputs, multiply, round and accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ld) begin
            r_cos <= i_cos_theta;
            r_sin <= i_sin_theta;
        end
        if (i_cmd.mul_en) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.rnd_en) begin
            case (i_cmd.acc_op)
                OP_TMP:  r_tmp <= OPA_W'(rnd_val);
                OP_LOAD: r_acc <= rnd_val;
                OP_SUB:  r_acc <= r_acc - rnd_val;
                default: r_acc <= r_acc;
            endcase
        end
        if (i_cmd.pval_ld) begin
            r_pval <= r_rd;
        end
    end

    // Result register: load an item, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_n    <= i_cmd.cur_row;
            r_out_m    <= i_cmd.cur_col;
            r_out_p    <= r_pval;
            r_out_d    <= acc_sat;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_stat.out_stall   = r_out_valid & ~i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_degree_index     = r_out_n;
    assign o_order_index      = r_out_m;
    assign o_legendre_value   = r_out_p;
    assign o_derivative_value = r_out_d;
    assign o_last_entry       = r_out_last;

endmodule

// ===== rtl/nlt_ctrl.sv =====
// Controller: sequences table fill and result emission, holds the degree register.
module nlt_ctrl import nlt_pkg::*; #(
    parameter int MAX_DEGREE = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cfg_we,
    input  t_idx       i_cfg_data,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    localparam t_idx MAX_DEG_IDX = IDX_W'(MAX_DEGREE);
    localparam t_idx LAST_ROW    = IDX_W'(MAX_DEGREE + 1);
    localparam logic HAS_GENERAL = (MAX_DEGREE >= 1);
    localparam t_idx DEG_RESET   = 4'd9;

    t_state r_state, n_state;
    t_idx   r_n, n_n;
    t_idx   r_m, n_m;
    t_idx   r_deg;
    t_idx   deg_eff;
    logic   is_last;

    assign deg_eff    = (r_deg > MAX_DEG_IDX) ? MAX_DEG_IDX : r_deg;
    assign is_last    = (r_n == deg_eff) && (r_m == r_n);
    assign o_in_ready = (r_state == ST_IDLE);

    // State, counters and degree register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_m     <= '0;
            r_deg   <= DEG_RESET;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_m     <= n_m;
            if (i_cfg_we) begin
                r_deg <= i_cfg_data;
            end
        end
    end

    // Next state and loop counters
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_m     = r_m;
        case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_P00;
            ST_P00:     n_state = ST_P10_MUL;
            ST_P10_MUL: n_state = ST_P10_RND;
            ST_P10_RND: n_state = ST_P10_WR;
            ST_P10_WR:  n_state = ST_P11_MUL;
            ST_P11_MUL: n_state = ST_P11_RND;
            ST_P11_RND: n_state = ST_P11_WR;
            ST_P11_WR: begin
                if (HAS_GENERAL) begin
                    n_n     = 4'd2;
                    n_state = ST_D_RD;
                end else begin
                    n_n     = '0;
                    n_state = ST_E_RDP;
                end
                n_m = '0;
            end
            ST_D_RD:    n_state = ST_D_MUL1;
            ST_D_MUL1:  n_state = ST_D_RND1;
            ST_D_RND1:  n_state = ST_D_MUL2;
            ST_D_MUL2:  n_state = ST_D_RND2;
            ST_D_RND2:  n_state = ST_D_WR;
            ST_D_WR: begin
                n_m     = '0;
                n_state = ST_O_RD;
            end
            ST_O_RD:    n_state = ST_O_MUL1;
            ST_O_MUL1:  n_state = ST_O_RND1;
            ST_O_RND1:  n_state = ST_O_MUL2;
            ST_O_MUL2:  n_state = ST_O_RND2;
            ST_O_RND2:  n_state = (r_n > r_m + 4'd1) ? ST_O_MUL3 : ST_O_WR;
            ST_O_MUL3:  n_state = ST_O_RND3;
            ST_O_RND3:  n_state = ST_O_WR;
            ST_O_WR: begin
                if (r_m + 4'd1 < r_n) begin
                    n_m     = r_m + 4'd1;
                    n_state = ST_O_RD;
                end else if (r_n == LAST_ROW) begin
                    n_n     = '0;
                    n_m     = '0;
                    n_state = ST_E_RDP;
                end else begin
                    n_n     = r_n + 4'd1;
                    n_state = ST_D_RD;
                end
            end
            ST_E_RDP:   n_state = ST_E_RDG;
            ST_E_RDG:   n_state = ST_E_MULG;
            ST_E_MULG:  n_state = ST_E_RNDG;
            ST_E_RNDG:  n_state = ST_E_MULF;
            ST_E_MULF:  n_state = ST_E_RNDF;
            ST_E_RNDF:  n_state = ST_E_OUT;
            ST_E_OUT: begin
                if (!i_stat.out_stall) begin
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else if (r_m == r_n) begin
                        n_n     = r_n + 4'd1;
                        n_m     = '0;
                        n_state = ST_E_RDP;
                    end else begin
                        n_m     = r_m + 4'd1;
                        n_state = ST_E_RDP;
                    end
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.cur_row  = r_n;
        o_cmd.cur_col  = r_m;
        o_cmd.addr_row = r_n;
        o_cmd.addr_col = r_m;
        o_cmd.b_coef   = 1'b1;
        o_cmd.a_sel    = A_RD;
        o_cmd.coef_sel = CF_S3;
        o_cmd.rnd_sel  = RND_26;
        o_cmd.acc_op   = OP_LOAD;
        case (r_state)
            ST_IDLE: o_cmd.in_ld = i_in_valid;
            ST_P00: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_one   = 1'b1;
                o_cmd.addr_row = 4'd0;
                o_cmd.addr_col = 4'd0;
            end
            ST_P10_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.a_sel  = A_COS;
            end
            ST_P11_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.a_sel  = A_SIN;
            end
            ST_P10_RND, ST_P11_RND: begin
                o_cmd.rnd_en  = 1'b1;
                o_cmd.rnd_sel = RND_32;
            end
            ST_P10_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.addr_row = 4'd1;
                o_cmd.addr_col = 4'd0;
            end
            ST_P11_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.addr_row = 4'd1;
                o_cmd.addr_col = 4'd1;
            end
            ST_D_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_row = r_n - 4'd1;
                o_cmd.addr_col = r_n - 4'd1;
            end
            ST_D_MUL1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.a_sel  = A_SIN;
                o_cmd.b_coef = 1'b0;
            end
            ST_D_RND1, ST_O_RND1: begin
                o_cmd.rnd_en  = 1'b1;
                o_cmd.rnd_sel = RND_30;
                o_cmd.acc_op  = OP_TMP;
            end
            ST_D_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.a_sel    = A_TMP;
                o_cmd.coef_sel = CF_DIAG;
            end
            ST_D_RND2, ST_O_RND2, ST_E_RNDG: begin
                o_cmd.rnd_en = 1'b1;
            end
            ST_D_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.addr_col = r_n;
            end
            ST_O_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_row = r_n - 4'd1;
            end
            ST_O_MUL1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.a_sel  = A_COS;
                o_cmd.b_coef = 1'b0;
            end
            ST_O_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.a_sel    = A_TMP;
                o_cmd.coef_sel = CF_A;
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_row = r_n - 4'd2;
            end
            ST_O_MUL3: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.coef_sel = CF_B;
            end
            ST_O_RND3, ST_E_RNDF: begin
                o_cmd.rnd_en = 1'b1;
                o_cmd.acc_op = OP_SUB;
            end
            ST_O_WR: o_cmd.wr_en = 1'b1;
            ST_E_RDP: o_cmd.rd_en = 1'b1;
            ST_E_RDG: begin
                o_cmd.pval_ld  = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_col = (r_m == 4'd0) ? 4'd0 : r_m - 4'd1;
            end
            ST_E_MULG: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.coef_sel = CF_DG;
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_col = r_m + 4'd1;
            end
            ST_E_MULF: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.coef_sel = CF_DF;
            end
            ST_E_OUT: begin
                o_cmd.out_ld   = ~i_stat.out_stall;
                o_cmd.out_last = is_last;
            end
            default: o_cmd.in_ld = 1'b0;
        endcase
    end

    // Accepted item starts the fill sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == ST_P00)
        else $error("accepted item did not start table fill");

    // Never load the result register over an item still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> !i_stat.out_stall)
        else $error("result register overwritten");

    // Emitted indexes stay inside the configured triangle
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_E_OUT |-> (r_m <= r_n) && (r_n <= deg_eff))
        else $error("emission index out of range");

    // Last result returns the controller to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld && o_cmd.out_last |=> r_state == ST_IDLE)
        else $error("last result did not end the item");

endmodule

// ===== rtl/normalized_legendre_table_top.sv =====
// After acceptance the controller fills the table, then emits the results one at a time,
// holding while the output stalls. All work shares the single multiplier and the
// single-port table memory. Input is ready only between items.
// Reset (synchronous, active low): controller idle, result register empty, degree 9.
// Top level: normalized associated Legendre table with colatitude derivatives.
module normalized_legendre_table_top import nlt_pkg::*; #(
    parameter int MAX_DEGREE = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_cos_theta,
    input  logic signed [DATA_W-1:0] i_sin_theta,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_idx                     o_degree_index,
    output t_idx                     o_order_index,
    output logic signed [DATA_W-1:0] o_legendre_value,
    output logic signed [DATA_W-1:0] o_derivative_value,
    output logic                     o_last_entry,
    input  logic                     i_cfg_we,
    input  t_idx                     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    nlt_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Arithmetic and table storage
    nlt_dpath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cos_theta        (i_cos_theta),
        .i_sin_theta        (i_sin_theta),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_degree_index     (o_degree_index),
        .o_order_index      (o_order_index),
        .o_legendre_value   (o_legendre_value),
        .o_derivative_value (o_derivative_value),
        .o_last_entry       (o_last_entry)
    );

endmodule
